[hdl/tcmc_pkg.sv]
// ============================================================================
// tcmc_pkg: shared types and constants for the text console
// Command codes, field widths and cell constants used by the console logic.
// ============================================================================
package tcmc_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int DELTA_W    = 8;
    localparam int CELL_IDX_W = 11;
    localparam int DATA_W     = 16;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT    = 2'd0,
        CMD_MOVE     = 2'd1,
        CMD_ACTIVATE = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [DATA_W-1:0] ATTR_MASK    = 16'hFF00;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;

    // swap foreground and background nibbles of the attribute byte
    function automatic logic [DATA_W-1:0] swap_nibbles(input logic [DATA_W-1:0] c);
        return {c[11:8], c[15:12], c[7:0]};
    endfunction

endpackage

[hdl/tcmc_ram.sv]
// ============================================================================
// tcmc_ram: screen cell store
// One write port and one read port; read data is registered.
// ============================================================================
module tcmc_ram
    import tcmc_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tcmc_addr_unit.sv]
// ============================================================================
// tcmc_addr_unit: shared cell address unit
// Registers row * columns + column for whichever cursor the sequencer selects.
// ============================================================================
module tcmc_addr_unit
    import tcmc_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int COL_W       = 7,
    parameter int ROW_W       = 5,
    parameter int ADDR_W      = 11
) (
    input  logic              i_clk,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_col,
    output logic [ADDR_W-1:0] o_idx
);

    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;

    // row and column are always on screen, so the sum never overflows
    assign n_idx = ADDR_W'(i_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(i_col);

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_idx = r_idx;

endmodule

[hdl/text_console_with_mouse_cursor.sv]
// ============================================================================
// text_console_with_mouse_cursor: text screen store with mouse pointer
// Character printing, pointer highlight and cell readback over one memory.
// ============================================================================
// Input channel (i_in_valid / o_in_stall) takes one command word: print a
// character, move the mouse, activate the mouse, or read a cell. Each word
// yields exactly one result word on the output channel (o_out_valid /
// i_out_stall) carrying the read data (zero unless a read) and both cursors.
// One word is worked on at a time; o_in_stall is high until the block is
// back in idle. A null print goes straight to the result, a newline
// moves the text cursor, a read reads and captures the cell; print and
// activate form the address, then read and rewrite the cell, and a mouse
// move does so for the old cell, moves the pointer and repeats for the new.
// A print or newline that runs off the last row rewrites every cell to a
// space, one cell per cycle. Reset is synchronous; afterwards the block
// fills every cell with a grey space while o_in_stall is high. The result
// sits in an output register; the next word is accepted while it waits,
// but a finished word holds while the previous result is still stalled.
// ============================================================================
module text_console_with_mouse_cursor
    import tcmc_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [CHAR_W-1:0]           i_char_code,
    input  logic signed [DELTA_W-1:0]   i_move_dx,
    input  logic signed [DELTA_W-1:0]   i_move_dy,
    input  logic [CELL_IDX_W-1:0]       i_cell_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [DATA_W-1:0]           o_read_data,
    output logic [OUT_COL_W-1:0]        o_text_col,
    output logic [OUT_ROW_W-1:0]        o_text_row,
    output logic [OUT_COL_W-1:0]        o_mouse_col,
    output logic [OUT_ROW_W-1:0]        o_mouse_row
);

    localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(SCREEN_COLS);
    localparam int RW         = $clog2(SCREEN_ROWS);
    localparam int CNTW       = $clog2(CELL_COUNT + 1);
    localparam int IW         = (AW > CELL_IDX_W) ? AW : CELL_IDX_W;
    localparam int SW         = 10;
    localparam int PTR_COL_RST = (SCREEN_COLS > 40) ? 40 : SCREEN_COLS - 1;
    localparam int PTR_ROW_RST = (SCREEN_ROWS > 12) ? 12 : SCREEN_ROWS - 1;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ADDR  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_MOD   = 8'b0001_0000,
        S_MOVE  = 8'b0010_0000,
        S_SWEEP = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // control registers
    t_state              r_state,     n_state;
    logic [CNTW-1:0]     r_sw,        n_sw;
    logic                r_wr_pend,   n_wr_pend;
    logic                r_phase,     n_phase;
    logic [CW-1:0]       r_cur_col,   n_cur_col;
    logic [RW-1:0]       r_cur_row,   n_cur_row;
    logic [CW-1:0]       r_ptr_col,   n_ptr_col;
    logic [RW-1:0]       r_ptr_row,   n_ptr_row;
    logic                r_out_valid, n_out_valid;

    // payload registers
    t_cmd                       r_cmd,      n_cmd;
    logic [CHAR_W-1:0]          r_ch,       n_ch;
    logic signed [DELTA_W-1:0]  r_dx,       n_dx;
    logic signed [DELTA_W-1:0]  r_dy,       n_dy;
    logic [CELL_IDX_W-1:0]      r_ci,       n_ci;
    logic [AW-1:0]              r_wr_addr,  n_wr_addr;
    logic [DATA_W-1:0]          r_rd_cap,   n_rd_cap;
    logic [DATA_W-1:0]          r_out_data, n_out_data;
    logic [OUT_COL_W-1:0]       r_out_tcol, n_out_tcol;
    logic [OUT_ROW_W-1:0]       r_out_trow, n_out_trow;
    logic [OUT_COL_W-1:0]       r_out_mcol, n_out_mcol;
    logic [OUT_ROW_W-1:0]       r_out_mrow, n_out_mrow;

    // memory and address unit hookup
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [DATA_W-1:0]   w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [DATA_W-1:0]   w_rdata;
    logic [AW-1:0]       w_idx;
    logic [RW-1:0]       w_au_row;
    logic [CW-1:0]       w_au_col;

    logic [IW-1:0]       w_ci_ext;
    logic                w_ci_ok;
    logic [CW:0]         w_col_inc;
    logic [RW:0]         w_row_inc;
    logic signed [SW-1:0] w_col_sum;
    logic signed [SW-1:0] w_row_sum;
    logic [CW-1:0]       w_col_clamp;
    logic [RW-1:0]       w_row_clamp;

    tcmc_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // print uses the text cursor, mouse commands the pointer
    assign w_au_row = (r_cmd == CMD_PRINT) ? r_cur_row : r_ptr_row;
    assign w_au_col = (r_cmd == CMD_PRINT) ? r_cur_col : r_ptr_col;

    tcmc_addr_unit #(
        .SCREEN_COLS (SCREEN_COLS),
        .COL_W       (CW),
        .ROW_W       (RW),
        .ADDR_W      (AW)
    ) u_addr (
        .i_clk (i_clk),
        .i_row (w_au_row),
        .i_col (w_au_col),
        .o_idx (w_idx)
    );

    assign w_ci_ext  = IW'(r_ci);
    assign w_ci_ok   = ((IW + 1)'(r_ci) < (IW + 1)'(CELL_COUNT));
    assign w_col_inc = {1'b0, r_cur_col} + 1'b1;
    assign w_row_inc = {1'b0, r_cur_row} + 1'b1;

    // wide signed add so a large delta never wraps, then clamp to the screen
    assign w_col_sum = $signed(SW'(r_ptr_col)) + SW'(r_dx);
    assign w_row_sum = $signed(SW'(r_ptr_row)) + SW'(r_dy);

    always_comb begin
        if (w_col_sum < 0) begin
            w_col_clamp = '0;
        end else if (w_col_sum >= $signed(SW'(SCREEN_COLS))) begin
            w_col_clamp = CW'(SCREEN_COLS - 1);
        end else begin
            w_col_clamp = w_col_sum[CW-1:0];
        end
        if (w_row_sum < 0) begin
            w_row_clamp = '0;
        end else if (w_row_sum >= $signed(SW'(SCREEN_ROWS))) begin
            w_row_clamp = RW'(SCREEN_ROWS - 1);
        end else begin
            w_row_clamp = w_row_sum[RW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sw        = r_sw;
        n_wr_pend   = r_wr_pend;
        n_phase     = r_phase;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_ptr_col   = r_ptr_col;
        n_ptr_row   = r_ptr_row;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_ci        = r_ci;
        n_wr_addr   = r_wr_addr;
        n_rd_cap    = r_rd_cap;
        n_out_data  = r_out_data;
        n_out_tcol  = r_out_tcol;
        n_out_trow  = r_out_trow;
        n_out_mcol  = r_out_mcol;
        n_out_mrow  = r_out_mrow;

        w_we    = 1'b0;
        w_waddr = w_idx;
        w_wdata = '0;
        w_raddr = w_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_sw[AW-1:0];
                w_wdata = BLANK_CELL;
                if (r_sw == CNTW'(CELL_COUNT - 1)) begin
                    n_sw    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sw = r_sw + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_ch    = i_char_code;
                    n_dx    = i_move_dx;
                    n_dy    = i_move_dy;
                    n_ci    = i_cell_index;
                    n_phase = 1'b0;
                    if (t_cmd'(i_cmd) == CMD_PRINT && i_char_code == NULL_CODE) begin
                        n_state = S_DONE;
                    end else if (t_cmd'(i_cmd) == CMD_READ) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                if (r_cmd == CMD_PRINT && r_ch == NEWLINE_CODE) begin
                    n_cur_col = '0;
                    if (w_row_inc == (RW + 1)'(SCREEN_ROWS)) begin
                        n_cur_row = '0;
                        n_sw      = '0;
                        n_wr_pend = 1'b0;
                        n_state   = S_SWEEP;
                    end else begin
                        n_cur_row = w_row_inc[RW-1:0];
                        n_state   = S_DONE;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_cmd == CMD_READ) begin
                    w_raddr = w_ci_ext[AW-1:0];
                end
                n_state = S_MOD;
            end
            S_MOD: begin
                case (r_cmd)
                    CMD_PRINT: begin
                        w_we    = 1'b1;
                        w_wdata = (w_rdata & ATTR_MASK) | DATA_W'(r_ch);
                        n_state = S_DONE;
                        if (w_col_inc == (CW + 1)'(SCREEN_COLS)) begin
                            n_cur_col = '0;
                            if (w_row_inc == (RW + 1)'(SCREEN_ROWS)) begin
                                n_cur_row = '0;
                                n_sw      = '0;
                                n_wr_pend = 1'b0;
                                n_state   = S_SWEEP;
                            end else begin
                                n_cur_row = w_row_inc[RW-1:0];
                            end
                        end else begin
                            n_cur_col = w_col_inc[CW-1:0];
                        end
                    end
                    CMD_MOVE: begin
                        w_we    = 1'b1;
                        w_wdata = swap_nibbles(w_rdata);
                        n_state = r_phase ? S_DONE : S_MOVE;
                    end
                    CMD_ACTIVATE: begin
                        w_we    = 1'b1;
                        w_wdata = swap_nibbles(w_rdata);
                        n_state = S_DONE;
                    end
                    CMD_READ: begin
                        n_rd_cap = w_ci_ok ? w_rdata : '0;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MOVE: begin
                n_ptr_col = w_col_clamp;
                n_ptr_row = w_row_clamp;
                n_phase   = 1'b1;
                n_state   = S_ADDR;
            end
            S_SWEEP: begin
                // read cell k while writing back cell k-1
                w_waddr = r_wr_addr;
                w_wdata = (w_rdata & ATTR_MASK) | DATA_W'(SPACE_CODE);
                w_we    = r_wr_pend;
                if (r_sw == CNTW'(CELL_COUNT)) begin
                    n_wr_pend = 1'b0;
                    n_sw      = '0;
                    n_state   = S_DONE;
                end else begin
                    w_raddr   = r_sw[AW-1:0];
                    n_wr_addr = r_sw[AW-1:0];
                    n_wr_pend = 1'b1;
                    n_sw      = r_sw + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_cmd == CMD_READ) ? r_rd_cap : '0;
                    n_out_tcol  = OUT_COL_W'(r_cur_col);
                    n_out_trow  = OUT_ROW_W'(r_cur_row);
                    n_out_mcol  = OUT_COL_W'(r_ptr_col);
                    n_out_mrow  = OUT_ROW_W'(r_ptr_row);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sw        <= '0;
            r_wr_pend   <= 1'b0;
            r_phase     <= 1'b0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_ptr_col   <= CW'(PTR_COL_RST);
            r_ptr_row   <= RW'(PTR_ROW_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sw        <= n_sw;
            r_wr_pend   <= n_wr_pend;
            r_phase     <= n_phase;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_ptr_col   <= n_ptr_col;
            r_ptr_row   <= n_ptr_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ch       <= n_ch;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_ci       <= n_ci;
        r_wr_addr  <= n_wr_addr;
        r_rd_cap   <= n_rd_cap;
        r_out_data <= n_out_data;
        r_out_tcol <= n_out_tcol;
        r_out_trow <= n_out_trow;
        r_out_mcol <= n_out_mcol;
        r_out_mrow <= n_out_mrow;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_text_col  = r_out_tcol;
    assign o_text_row  = r_out_trow;
    assign o_mouse_col = r_out_mcol;
    assign o_mouse_row = r_out_mrow;

endmodule

[hdl/tcmc_checker.sv]
// ============================================================================
// tcmc_checker: port-level checks for the text console
// Watches the top-level handshakes and result words over time.
// ============================================================================
module tcmc_checker
    import tcmc_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_W-1:0]     o_read_data,
    input logic [OUT_COL_W-1:0]  o_text_col,
    input logic [OUT_ROW_W-1:0]  o_text_row,
    input logic [OUT_COL_W-1:0]  o_mouse_col,
    input logic [OUT_ROW_W-1:0]  o_mouse_row
);

    // reset drops any pending result word
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result word stays put
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result word changed");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // both cursors stay on screen
    a_cols_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_text_col) < SCREEN_COLS) && (32'(o_mouse_col) < SCREEN_COLS))
        else $error("cursor column off screen");

    a_rows_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_text_row) < SCREEN_ROWS) && (32'(o_mouse_row) < SCREEN_ROWS))
        else $error("cursor row off screen");

endmodule

bind text_console_with_mouse_cursor tcmc_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tcmc_checker (.*);
